// File: src/owr_pkg.sv
// Shared types, constants and helper functions for the one-wire temperature reader.
// Used by owr_csr, owr_seq and the top level one_wire_temperature_reader_unit.
package owr_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] KIND_TICK           = 2'd0;
   localparam logic [1:0] KIND_START_READ     = 2'd1;
   localparam logic [1:0] KIND_START_PRESENCE = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RESET_LOW_US   = 2'd0;
   localparam logic [1:0] CSR_PRES_WAIT_POLL = 2'd1;
   localparam logic [1:0] CSR_PRES_HOLD_POLL = 2'd2;

   // Configuration reset values.
   localparam logic [9:0] RESET_LOW_US_DEFAULT   = 10'd750;
   localparam logic [5:0] PRES_WAIT_POLL_DEFAULT = 6'd50;
   localparam logic [5:0] PRES_HOLD_POLL_DEFAULT = 6'd60;

   // Bus timing in microseconds.
   localparam logic [9:0] RESET_HIGH_US  = 10'd16;
   localparam logic [9:0] POLL_US        = 10'd4;
   localparam logic [9:0] WRITE_SLOT_US  = 10'd64;
   localparam logic [9:0] WRITE_ONE_LOW  = 10'd4;
   localparam logic [9:0] WRITE_ZERO_LOW = 10'd60;
   localparam logic [9:0] READ_SLOT_US   = 10'd70;
   localparam logic [9:0] READ_LOW_US    = 10'd8;
   localparam logic [9:0] READ_SAMPLE_AT = 10'd20;

   // Sequence steps: four command bytes, two read bytes, then the end.
   localparam logic [2:0] STEP_SECOND_RESET  = 3'd2;
   localparam logic [2:0] STEP_READ_LOW      = 3'd4;
   localparam logic [2:0] STEP_READ_HIGH     = 3'd5;
   localparam logic [2:0] STEP_PRESENCE_ONLY = 3'd6;
   localparam logic [2:0] LAST_BIT           = 3'd7;

   // Command bytes.
   localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
   localparam logic [7:0] CMD_CONVERT   = 8'h44;
   localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

   // Sign threshold on the high byte.
   localparam logic [7:0] HIGH_BYTE_POS_MAX = 8'd7;

   typedef struct packed {
      logic [1:0] kind;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic               drive_low;
      logic               busy_res;
      logic               done_res;
      logic               presence_missing;
      logic signed [15:0] temperature_tenths;
   } rsp_type;

   typedef struct packed {
      logic [9:0] reset_low_us;
      logic [5:0] presence_wait_polls;
      logic [5:0] presence_hold_polls;
   } cfg_type;

   // Command byte sent at each write step of the temperature read.
   function automatic logic [7:0] command_byte(input logic [1:0] step);
      logic [7:0] b;
      case (step)
         2'd0:    b = CMD_SKIP_ROM;
         2'd1:    b = CMD_CONVERT;
         2'd2:    b = CMD_SKIP_ROM;
         2'd3:    b = CMD_READ_PAD;
         default: b = CMD_SKIP_ROM;
      endcase
      return b;
   endfunction

   // Raw sensor reading to tenths of a degree: magnitude * 5 / 8, sign restored, saturated.
   function automatic logic signed [15:0] tenths_of(input logic [7:0] high_byte,
                                                    input logic [7:0] low_byte);
      logic [15:0] raw;
      logic        neg;
      logic [15:0] mag;
      logic [18:0] prod;
      logic [15:0] tenths;
      logic [15:0] res;
      raw    = {high_byte, low_byte};
      neg    = high_byte > HIGH_BYTE_POS_MAX;
      mag    = neg ? (~raw + 16'd1) : raw;
      prod   = {1'b0, mag, 2'b00} + {3'b000, mag};
      tenths = prod[18:3];
      if (neg) begin
         res = tenths[15] ? 16'h8000 : (~tenths + 16'd1);
      end else begin
         res = tenths[15] ? 16'h7FFF : tenths;
      end
      return signed'(res);
   endfunction

endpackage

// File: src/owr_csr.sv
// Configuration registers of the one-wire temperature reader.
// Depends on owr_pkg for the register indexes, reset values and cfg_type.
module owr_csr
   import owr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_wdata,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register; other indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RESET_LOW_US:   cfg_in.reset_low_us        = csr_wdata;
            CSR_PRES_WAIT_POLL: cfg_in.presence_wait_polls = csr_wdata[5:0];
            CSR_PRES_HOLD_POLL: cfg_in.presence_hold_polls = csr_wdata[5:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us        <= RESET_LOW_US_DEFAULT;
         cfg_ff.presence_wait_polls <= PRES_WAIT_POLL_DEFAULT;
         cfg_ff.presence_hold_polls <= PRES_HOLD_POLL_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/owr_seq.sv
// Bus sequencer: holds the sequence state and works out one item per step.
// Depends on owr_pkg for timing constants, command bytes and the temperature conversion.
module owr_seq
   import owr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_RST_LOW   = 3'd1;
   localparam logic [2:0] PH_RST_HIGH  = 3'd2;
   localparam logic [2:0] PH_PRES_WAIT = 3'd3;
   localparam logic [2:0] PH_PRES_HOLD = 3'd4;
   localparam logic [2:0] PH_WRITE     = 3'd5;
   localparam logic [2:0] PH_READ      = 3'd6;

   logic [2:0]         phase_ff, phase_in;
   logic [9:0]         usec_ff, usec_in;
   logic [5:0]         poll_ff, poll_in;
   logic [2:0]         bit_ff, bit_in;
   logic [7:0]         shift_ff, shift_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [7:0]         low_ff, low_in;
   logic               pres_err_ff, pres_err_in;
   logic signed [15:0] temp_ff, temp_in;

   // Bus drive level for a given state.
   function automatic logic drive_of(input logic [2:0] ph, input logic [9:0] us,
                                     input logic bit_val);
      logic d;
      case (ph)
         PH_RST_LOW: d = 1'b1;
         PH_WRITE:   d = us < (bit_val ? WRITE_ONE_LOW : WRITE_ZERO_LOW);
         PH_READ:    d = us < READ_LOW_US;
         default:    d = 1'b0;
      endcase
      return d;
   endfunction

   logic       finished;
   logic       drive;
   logic       begin_req;
   logic [2:0] begin_cmd;
   logic [9:0] usec_inc;
   logic [9:0] poll_us;
   logic       waiting;
   logic [5:0] limit;
   logic [2:0] cmd_next;
   logic [7:0] sampled;

   // Next state and result for the current item.
   always_comb begin
      phase_in    = phase_ff;
      usec_in     = usec_ff;
      poll_in     = poll_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      cmd_in      = cmd_ff;
      low_in      = low_ff;
      pres_err_in = pres_err_ff;
      temp_in     = temp_ff;
      finished    = 1'b0;
      begin_req   = 1'b0;
      begin_cmd   = cmd_ff;
      usec_inc    = usec_ff + 10'd1;
      poll_us     = (usec_inc >= POLL_US) ? 10'd0 : usec_inc;
      waiting     = phase_ff == PH_PRES_WAIT;
      limit       = waiting ? cfg.presence_wait_polls : cfg.presence_hold_polls;
      cmd_next    = cmd_ff + 3'd1;
      sampled     = (usec_ff == READ_SAMPLE_AT) ? {item.line_level, shift_ff[7:1]} : shift_ff;
      drive       = 1'b0;

      if (item.kind == KIND_TICK) begin
         drive = drive_of(phase_ff, usec_ff, shift_ff[0]);
         case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_RST_LOW: begin
               if (usec_inc >= cfg.reset_low_us) begin
                  phase_in = PH_RST_HIGH;
                  usec_in  = 10'd0;
               end else begin
                  usec_in = usec_inc;
               end
            end
            PH_RST_HIGH: begin
               if (usec_inc >= RESET_HIGH_US) begin
                  phase_in = PH_PRES_WAIT;
                  usec_in  = 10'd0;
                  poll_in  = 6'd0;
               end else begin
                  usec_in = usec_inc;
               end
            end
            PH_PRES_WAIT, PH_PRES_HOLD: begin
               if (usec_ff == 10'd0) begin
                  // A poll samples the line on its first microsecond.
                  if (poll_ff >= limit) begin
                     pres_err_in = 1'b1;
                     begin_req   = 1'b1;
                  end else if (waiting && !item.line_level) begin
                     phase_in = PH_PRES_HOLD;
                     poll_in  = 6'd0;
                  end else if (!waiting && item.line_level) begin
                     begin_req = 1'b1;
                  end else begin
                     poll_in = poll_ff + 6'd1;
                     usec_in = poll_us;
                  end
               end else begin
                  usec_in = poll_us;
               end
            end
            PH_WRITE: begin
               if (usec_inc >= WRITE_SLOT_US) begin
                  usec_in  = 10'd0;
                  shift_in = {1'b0, shift_ff[7:1]};
                  if (bit_ff == LAST_BIT) begin
                     bit_in = 3'd0;
                     cmd_in = cmd_next;
                     if (cmd_next == STEP_SECOND_RESET) begin
                        phase_in = PH_RST_LOW;
                     end else begin
                        begin_req = 1'b1;
                        begin_cmd = cmd_next;
                     end
                  end else begin
                     bit_in = bit_ff + 3'd1;
                  end
               end else begin
                  usec_in = usec_inc;
               end
            end
            PH_READ: begin
               shift_in = sampled;
               if (usec_inc >= READ_SLOT_US) begin
                  usec_in = 10'd0;
                  if (bit_ff == LAST_BIT) begin
                     bit_in = 3'd0;
                     if (cmd_ff == STEP_READ_LOW) begin
                        low_in    = sampled;
                        cmd_in    = STEP_READ_HIGH;
                        begin_req = 1'b1;
                        begin_cmd = STEP_READ_HIGH;
                     end else begin
                        temp_in  = tenths_of(sampled, low_ff);
                        phase_in = PH_IDLE;
                        finished = 1'b1;
                     end
                  end else begin
                     bit_in = bit_ff + 3'd1;
                  end
               end else begin
                  usec_in = usec_inc;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // Start the next step of the sequence: a write, a read or the end.
         if (begin_req) begin
            usec_in = 10'd0;
            bit_in  = 3'd0;
            if (begin_cmd >= STEP_PRESENCE_ONLY) begin
               phase_in = PH_IDLE;
               finished = 1'b1;
            end else if (begin_cmd < STEP_READ_LOW) begin
               shift_in = command_byte(begin_cmd[1:0]);
               phase_in = PH_WRITE;
            end else begin
               shift_in = 8'd0;
               phase_in = PH_READ;
            end
         end
      end else begin
         // A start item arms the sequence only when idle; no time passes.
         if (phase_ff == PH_IDLE &&
             (item.kind == KIND_START_READ || item.kind == KIND_START_PRESENCE)) begin
            phase_in    = PH_RST_LOW;
            usec_in     = 10'd0;
            poll_in     = 6'd0;
            bit_in      = 3'd0;
            shift_in    = 8'd0;
            pres_err_in = 1'b0;
            cmd_in      = (item.kind == KIND_START_READ) ? 3'd0 : STEP_PRESENCE_ONLY;
         end
         drive = drive_of(phase_in, usec_in, shift_in[0]);
      end

      result.drive_low          = drive;
      result.busy_res           = phase_in != PH_IDLE;
      result.done_res           = finished;
      result.presence_missing   = pres_err_in;
      result.temperature_tenths = temp_in;
   end

   // Control state is cleared by reset; the data bytes are cleared too to match start-up.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         usec_ff     <= 10'd0;
         poll_ff     <= 6'd0;
         bit_ff      <= 3'd0;
         shift_ff    <= 8'd0;
         cmd_ff      <= 3'd0;
         low_ff      <= 8'd0;
         pres_err_ff <= 1'b0;
         temp_ff     <= 16'sd0;
      end else if (step) begin
         phase_ff    <= phase_in;
         usec_ff     <= usec_in;
         poll_ff     <= poll_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         cmd_ff      <= cmd_in;
         low_ff      <= low_in;
         pres_err_ff <= pres_err_in;
         temp_ff     <= temp_in;
      end
   end

endmodule

// File: src/one_wire_temperature_reader_unit.sv
// One-wire temperature reader: input register, sequencer step, result register.
// Path: the item waits in the input register until the sequencer steps it, and the
// step loads its result into the result register.
// Throughput: one item per cycle when rsp_stall is low, set by the single step per item.
// Reset: synchronous, active high; clears both pipeline valid flags and the sequence
// state and returns the configuration registers to their default values.
module one_wire_temperature_reader_unit
   import owr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   cfg_type cfg;
   rsp_type result;
   logic    step;
   logic    req_take;

   owr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   owr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // The held item moves on whenever the result register is free or being taken.
   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (step) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on their handshakes.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
